// ===== hw/rtl/vdim_pkg.sv =====
// Package for the vertex deduplication block: table sizes, vertex and
// result types, and the controller state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdim_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Fixed widths of the result fields.
    localparam int OUT_IDX_W    = 8;
    localparam int OUT_CNT_W    = 9;

    // One vertex as stored in the table.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vertex;

    localparam int VTX_W = $bits(t_vertex);

    // One result beat.
    typedef struct packed {
        logic                 valid;
        logic [OUT_IDX_W-1:0] index;
        logic                 is_new;
        logic                 full;
        logic [OUT_CNT_W-1:0] count;
    } t_result;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/vertex_dedup_index_map.sv =====
// Vertex deduplication: exact match of x, y, z against a table of distinct vertices.
// After an accept, busy stays high while the table is scanned, until a hit or a miss;
// the scan stops at the matching entry on a hit and covers every entry on a miss.
// The result strobe comes in the first cycle with busy low, and a new beat can be
// accepted at its end; no new beat is taken while busy is high.
// Synchronous active-low reset empties the table; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_index_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_start_of_set,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    output logic             o_strobe,
    output logic [vdim_pkg::OUT_IDX_W-1:0] o_unique_index,
    output logic             o_is_new,
    output logic             o_table_full,
    output logic [vdim_pkg::OUT_CNT_W-1:0] o_distinct_count
);
    import vdim_pkg::*;

    logic             w_accept;
    t_vertex          r_vtx;
    t_vertex          w_vtx_in;
    t_vertex          w_rd_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_result          w_result;
    t_result          r_result;

    assign w_accept   = start && !busy;
    assign w_vtx_in.x = i_coord_x;
    assign w_vtx_in.y = i_coord_y;
    assign w_vtx_in.z = i_coord_z;

    // Hold the vertex of the accepted beat for the whole scan.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vtx <= w_vtx_in;
        end
    end

    vdim_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (VTX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_vtx),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    vdim_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_start_of_set (i_start_of_set),
        .i_vtx          (r_vtx),
        .i_rd_data      (w_rd_data),
        .o_busy         (busy),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_result       (w_result)
    );

    // Result register: each beat is shown for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result.valid <= 1'b0;
        end else begin
            r_result.valid <= w_result.valid;
        end
        if (w_result.valid) begin
            r_result.index  <= w_result.index;
            r_result.is_new <= w_result.is_new;
            r_result.full   <= w_result.full;
            r_result.count  <= w_result.count;
        end
    end

    assign o_strobe         = r_result.valid;
    assign o_unique_index   = r_result.index;
    assign o_is_new         = r_result.is_new;
    assign o_table_full     = r_result.full;
    assign o_distinct_count = r_result.count;

endmodule

`default_nettype wire

// ===== hw/rtl/vdim_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vdim_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, updated only when the read enable is high.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vdim_ctrl.sv =====
// Scan controller: walks the vertex table one entry a cycle, compares the
// read data with the held vertex, and decides hit, append or full. Uses vdim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vdim_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_start_of_set,
    input  wire vdim_pkg::t_vertex i_vtx,
    input  wire vdim_pkg::t_vertex i_rd_data,
    output logic                  o_busy,
    output logic                  o_rd_en,
    output logic [vdim_pkg::IDX_W-1:0] o_rd_addr,
    output logic                  o_wr_en,
    output logic [vdim_pkg::IDX_W-1:0] o_wr_addr,
    output vdim_pkg::t_result     o_result
);
    import vdim_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    logic             w_hit;
    logic             w_more;
    logic             w_miss;
    logic             w_full;
    logic [CNT_W-1:0] w_count_inc;

    // Compare and scan-progress terms.
    assign w_hit       = (r_state == ST_SCAN) && r_rd_vld && (i_rd_data == i_vtx);
    assign w_more      = r_issue < r_count;
    assign w_miss      = (r_state == ST_SCAN) && !r_rd_vld && !w_more;
    assign w_full      = r_count == CNT_W'(MAX_VERTICES);
    assign w_count_inc = r_count + CNT_W'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit || w_miss) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath control, table access and result.
    always_comb begin
        n_count   = r_count;
        n_issue   = r_issue;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_rd_idx;
        o_busy    = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_issue[IDX_W-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[IDX_W-1:0];
        o_result  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_issue = '0;
                    if (i_start_of_set) begin
                        n_count = '0;
                    end
                end
            end
            ST_SCAN: begin
                o_busy = 1'b1;
                // Keep one read in flight until a hit or the last entry.
                if (!w_hit && w_more) begin
                    o_rd_en  = 1'b1;
                    n_issue  = r_issue + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_issue[IDX_W-1:0];
                end
                if (w_hit) begin
                    o_result.valid = 1'b1;
                    o_result.index = OUT_IDX_W'(r_rd_idx);
                    o_result.count = OUT_CNT_W'(r_count);
                end else if (w_miss) begin
                    o_result.valid = 1'b1;
                    if (w_full) begin
                        o_result.full  = 1'b1;
                        o_result.count = OUT_CNT_W'(r_count);
                    end else begin
                        o_wr_en         = 1'b1;
                        n_count         = w_count_inc;
                        o_result.is_new = 1'b1;
                        o_result.index  = OUT_IDX_W'(r_count);
                        o_result.count  = OUT_CNT_W'(w_count_inc);
                    end
                end
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_issue  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Index of the entry whose data is on the read port.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
    end

endmodule

`default_nettype wire

// ===== verif/vertex_dedup_index_map_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vertex_dedup_index_map. Vertices go in through the
// start/busy handshake, and a table model predicts every remap beat for checking.
// Depends on vdim_pkg and the vertex_dedup_index_map RTL.

module vertex_dedup_index_map_tb;

    import vdim_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_PRINTED    = 100;

    localparam logic signed [31:0] COORD_MIN  = 32'h8000_0000;
    localparam logic signed [31:0] COORD_MAX  = 32'h7fff_ffff;
    localparam logic signed [31:0] COORD_ZERO = 32'h0000_0000;
    localparam logic signed [31:0] COORD_NEG1 = 32'hffff_ffff;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_start_of_set;
    logic signed [31:0]    i_coord_x;
    logic signed [31:0]    i_coord_y;
    logic signed [31:0]    i_coord_z;
    logic                  o_strobe;
    logic [OUT_IDX_W-1:0]  o_unique_index;
    logic                  o_is_new;
    logic                  o_table_full;
    logic [OUT_CNT_W-1:0]  o_distinct_count;

    // Model of the distinct vertex table and the remaps still owed by the block.
    t_vertex     known_vertices [MAX_VERTICES];
    int unsigned known_count;
    t_result     expected_remaps [$];
    int          mismatch_count;
    int          sender_idle_pct;

    vertex_dedup_index_map DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_start_of_set   (i_start_of_set),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .o_strobe         (o_strobe),
        .o_unique_index   (o_unique_index),
        .o_is_new         (o_is_new),
        .o_table_full     (o_table_full),
        .o_distinct_count (o_distinct_count)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Searches the model table for an exact match, appends the vertex when it is new,
    // and queues the remap the block must return.
    task automatic dedup_predict(input logic sos, input t_vertex v);
        t_result     r;
        int unsigned k;
        bit          hit;
        r       = '0;
        r.valid = 1'b1;
        hit     = 1'b0;
        if (sos) begin
            known_count = 0;
        end
        for (k = 0; k < known_count; k++) begin
            if (!hit && known_vertices[k] == v) begin
                r.index = OUT_IDX_W'(k);
                hit     = 1'b1;
            end
        end
        if (!hit) begin
            if (known_count < MAX_VERTICES) begin
                r.index                     = OUT_IDX_W'(known_count);
                known_vertices[known_count] = v;
                known_count++;
                r.is_new = 1'b1;
            end else begin
                // Table full: nothing stored, index reads as zero.
                r.full = 1'b1;
            end
        end
        r.count = OUT_CNT_W'(known_count);
        expected_remaps.push_back(r);
    endtask

    // Sends one vertex beat, with an optional idle gap first, and waits for its accept.
    // Start is left high so that a following beat can go out back to back.
    task automatic send_vertex(input logic sos, input t_vertex v);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 300)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_start_of_set <= sos;
        i_coord_x      <= v.x;
        i_coord_y      <= v.y;
        i_coord_z      <= v.z;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        dedup_predict(sos, v);
    endtask

    // Holds the sender off until every outstanding remap beat has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_remaps.size() != 0) @(posedge i_clk);
    endtask

    // Mostly full-range random values, with the corner values mixed in.
    function automatic logic [31:0] pick_coordinate();
        logic [31:0] corner [5];
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
        if ($urandom_range(0, 7) == 0) begin
            return corner[$urandom_range(0, 4)];
        end
        return $urandom();
    endfunction

    function automatic t_vertex random_vertex();
        return t_vertex'{pick_coordinate(), pick_coordinate(), pick_coordinate()};
    endfunction

    // A vertex that differs from the given one in a single bit of one coordinate.
    function automatic t_vertex near_vertex(input t_vertex v);
        int unsigned bit_pos;
        bit_pos    = $urandom_range(0, VTX_W - 1);
        v[bit_pos] = ~v[bit_pos];
        return v;
    endfunction

    // The table starts empty after reset, even without start_of_set.
    task automatic test_first_vertex_after_reset();
        send_vertex(1'b0, t_vertex'{32'sd5, -32'sd7, 32'sd9});
        send_vertex(1'b0, t_vertex'{32'sd5, -32'sd7, 32'sd9});
        send_vertex(1'b0, t_vertex'{32'sd5, -32'sd7, 32'sd8});
        wait_for_results();
    endtask

    // Corner coordinates, vertices that differ in only one coordinate, repeats,
    // and start_of_set on a vertex that was already stored.
    task automatic test_coordinate_extremes();
        send_vertex(1'b1, t_vertex'{COORD_MIN, COORD_MIN, COORD_MIN});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MAX, COORD_MAX});
        send_vertex(1'b0, t_vertex'{COORD_ZERO, COORD_ZERO, COORD_ZERO});
        send_vertex(1'b0, t_vertex'{COORD_NEG1, COORD_NEG1, COORD_NEG1});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MAX, COORD_MIN});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MIN, COORD_MAX});
        send_vertex(1'b0, t_vertex'{COORD_MIN, COORD_MAX, COORD_MAX});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MAX, COORD_MAX});
        send_vertex(1'b0, t_vertex'{COORD_MIN, COORD_MIN, COORD_MIN});
        send_vertex(1'b0, t_vertex'{COORD_NEG1, COORD_NEG1, COORD_NEG1});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MIN, COORD_MAX});
        send_vertex(1'b1, t_vertex'{COORD_MAX, COORD_MAX, COORD_MAX});
        send_vertex(1'b0, t_vertex'{COORD_MIN, COORD_MIN, COORD_MIN});
        send_vertex(1'b0, t_vertex'{COORD_MAX, COORD_MAX, COORD_MAX});
        wait_for_results();
    endtask

    // Fills all entries, then sends new vertices to a full table, hits on the first
    // and last entries, and empties the table again with start_of_set.
    task automatic test_table_full();
        t_vertex first_entry;
        t_vertex last_entry;
        t_vertex v;
        int      k;
        for (k = 0; k < MAX_VERTICES; k++) begin
            v = t_vertex'{k, $urandom(), $urandom()};
            if (k == 0) begin
                first_entry = v;
            end
            last_entry = v;
            send_vertex(k == 0, v);
        end
        send_vertex(1'b0, t_vertex'{MAX_VERTICES, $urandom(), $urandom()});
        send_vertex(1'b0, near_vertex(last_entry));
        send_vertex(1'b0, last_entry);
        send_vertex(1'b0, first_entry);
        send_vertex(1'b0, t_vertex'{COORD_NEG1, COORD_NEG1, COORD_NEG1});
        send_vertex(1'b1, last_entry);
        send_vertex(1'b0, first_entry);
        wait_for_results();
    endtask

    // Random vertex sets: each set draws fresh vertices, single-bit neighbors of earlier
    // ones, and repeats. Now and then a set runs past the table depth.
    task automatic test_random_sets(input int idle_pct, input int item_goal);
        t_vertex set_vertices [$];
        t_vertex v;
        int      sent;
        int      set_len;
        int      fresh_pct;
        int      n;
        int      pick;
        logic    sos;
        bit      long_set;
        sender_idle_pct = idle_pct;
        sent            = 0;
        while (sent < item_goal) begin
            long_set  = ($urandom_range(0, 59) == 0);
            set_len   = long_set ? $urandom_range(300, 340) : $urandom_range(1, 24);
            fresh_pct = long_set ? 85 : 30;
            set_vertices.delete();
            for (n = 0; n < set_len; n++) begin
                pick = $urandom_range(0, 99);
                if (set_vertices.size() == 0 || pick < fresh_pct) begin
                    v = random_vertex();
                    set_vertices.push_back(v);
                end else if (pick < fresh_pct + 15) begin
                    v = near_vertex(set_vertices[$urandom_range(0, set_vertices.size() - 1)]);
                    set_vertices.push_back(v);
                end else begin
                    v = set_vertices[$urandom_range(0, set_vertices.size() - 1)];
                end
                // A set normally opens with start_of_set; sometimes it carries on the
                // old table, and a stray start_of_set may cut it short.
                if (n == 0) begin
                    sos = ($urandom_range(0, 9) != 0);
                end else begin
                    sos = ($urandom_range(0, 99) == 0);
                end
                send_vertex(sos, v);
                sent++;
                if ($urandom_range(0, 59) == 0) begin
                    wait_for_results();
                end
            end
        end
        wait_for_results();
    endtask

    // Compares each remap beat with the oldest prediction.
    always @(posedge i_clk) begin : check_remaps
        t_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_remaps.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = expected_remaps.pop_front();
                if (o_unique_index !== want.index) begin
                    report_mismatch($sformatf("unique_index %0d, expected %0d",
                                              o_unique_index, want.index));
                end
                if (o_is_new !== want.is_new) begin
                    report_mismatch($sformatf("is_new %b, expected %b",
                                              o_is_new, want.is_new));
                end
                if (o_table_full !== want.full) begin
                    report_mismatch($sformatf("table_full %b, expected %b",
                                              o_table_full, want.full));
                end
                if (o_distinct_count !== want.count) begin
                    report_mismatch($sformatf("distinct_count %0d, expected %0d",
                                              o_distinct_count, want.count));
                end
            end
        end
    end

    // Ends the run when no beat moves in either direction for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Reset, the directed tests, then random sets under three idle patterns.
    initial begin
        start           <= 1'b0;
        i_rst_n         <= 1'b0;
        i_start_of_set  <= 1'b0;
        i_coord_x       <= '0;
        i_coord_y       <= '0;
        i_coord_z       <= '0;
        mismatch_count  = 0;
        known_count     = 0;
        sender_idle_pct = 20;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_vertex_after_reset();
        test_coordinate_extremes();
        test_table_full();
        test_random_sets(20, 380);
        test_random_sets(55, 380);
        test_random_sets(0, 380);

        // Let any stray beat show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_remaps.size() != 0) begin
            report_mismatch($sformatf("%0d remaps never returned", expected_remaps.size()));
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
